>>> hw/rtl/dns_name_decompressor_defines.svh
// ----------------------------------------------------------------------------
// dns name decompressor assertion macros
// shared helpers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_DECOMPRESSOR_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define DND_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define DND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg
// types and constants shared by the dns name decompressor modules
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int NAME_MAX_DEF     = 255;

    localparam int NAME_LEN_W = 8;
    localparam int HOPS_W     = 6;
    localparam int CHUNK_W    = 64;

    localparam logic [HOPS_W-1:0] MAX_HOPS_RST = 6'd16;

    localparam logic [7:0] PTR_MARK = 8'd192;
    localparam logic [7:0] DOT_CHAR = 8'h2e;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_HOPS      = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_PAST_END  = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [8:0] address;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [CHUNK_W-1:0] name_chunk;
        logic [3:0]         chunk_length;
        logic               last_chunk;
        logic [9:0]         bytes_consumed;
        logic [1:0]         status;
    } t_out_item;

endpackage

>>> hw/rtl/dnd_pkt_mem.sv
// ----------------------------------------------------------------------------
// dnd_pkt_mem
// packet byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dnd_pkt_mem #(
    parameter int DEPTH = dnd_pkg::PACKET_BYTES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/dnd_text_buf.sv
// ----------------------------------------------------------------------------
// dnd_text_buf
// dotted name text, 8-byte rows with a byte-lane write
// ----------------------------------------------------------------------------
module dnd_text_buf #(
    parameter int ROWS = 32,
    localparam int RW = $clog2(ROWS)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [RW-1:0]                i_wrow,
    input  logic [2:0]                   i_wlane,
    input  logic [7:0]                   i_wbyte,
    input  logic [RW-1:0]                i_rrow,
    output logic [dnd_pkg::CHUNK_W-1:0]  o_rdata
);

    logic [dnd_pkg::CHUNK_W-1:0] r_mem [ROWS];
    logic [dnd_pkg::CHUNK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wrow][i_wlane*8 +: 8] <= i_wbyte;
        end
        r_rdata <= r_mem[i_rrow];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/dnd_walker.sv
// ----------------------------------------------------------------------------
// dnd_walker
// load and decode sequencer: walks labels and pointers, then emits chunks
// ----------------------------------------------------------------------------
module dnd_walker #(
    parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
    parameter int NAME_MAX_BYTES = dnd_pkg::NAME_MAX_DEF,
    localparam int AW        = $clog2(PACKET_BYTES),
    localparam int TEXT_ROWS = (NAME_MAX_BYTES + 7) / 8,
    localparam int RW        = $clog2(TEXT_ROWS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dnd_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dnd_pkg::t_out_item           o_out_item,
    input  logic [dnd_pkg::HOPS_W-1:0]   i_max_hops,
    output logic                         o_pkt_we,
    output logic [AW-1:0]                o_pkt_waddr,
    output logic [7:0]                   o_pkt_wdata,
    output logic [AW-1:0]                o_pkt_raddr,
    input  logic [7:0]                   i_pkt_rdata,
    output logic                         o_txt_we,
    output logic [RW-1:0]                o_txt_wrow,
    output logic [2:0]                   o_txt_wlane,
    output logic [7:0]                   o_txt_wbyte,
    output logic [RW-1:0]                o_txt_rrow,
    input  logic [dnd_pkg::CHUNK_W-1:0]  i_txt_rdata
);

    localparam int POS_W = ((AW > 14) ? AW : 14) + 1;
    localparam logic [POS_W-1:0] PB_POS   = POS_W'(PACKET_BYTES);
    localparam logic [9:0]       NAME_MAX = 10'(NAME_MAX_BYTES);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_LEN_ISSUE = 8'b0000_0010,
        S_LEN_WAIT  = 8'b0000_0100,
        S_LABEL     = 8'b0000_1000,
        S_PTR       = 8'b0001_0000,
        S_EMIT_RD   = 8'b0010_0000,
        S_EMIT_LD   = 8'b0100_0000,
        S_EMIT_WAIT = 8'b1000_0000
    } t_state;

    t_state                           r_state, n_state;
    logic                             r_out_valid, n_out_valid;
    dnd_pkg::t_out_item               r_out, n_out;
    logic [POS_W-1:0]                 r_pos, n_pos;
    logic [8:0]                       r_start, n_start;
    logic [dnd_pkg::NAME_LEN_W-1:0]   r_len, n_len;
    logic [dnd_pkg::HOPS_W-1:0]       r_hops, n_hops;
    logic                             r_jumped, n_jumped;
    logic [9:0]                       r_consumed, n_consumed;
    logic [7:0]                       r_rem, n_rem;
    logic [5:0]                       r_ptr_hi, n_ptr_hi;
    logic [RW-1:0]                    r_row, n_row;

    logic                             w_err;
    logic [1:0]                       w_err_code;
    logic [9:0]                       w_need;
    logic [POS_W-1:0]                 w_pos_p1;
    logic [POS_W-1:0]                 w_pos_pb;
    logic [POS_W-1:0]                 w_rel;
    logic [8:0]                       w_base;
    logic [8:0]                       w_left;
    logic [3:0]                       w_cnt;
    logic [dnd_pkg::CHUNK_W-1:0]      w_word;

    assign w_pos_p1 = r_pos + POS_W'(1);
    assign w_pos_pb = r_pos + POS_W'(i_pkt_rdata);
    assign w_rel    = r_pos - POS_W'(r_start);
    assign w_need   = {2'b00, r_len} + {9'd0, (r_len != '0)} + {2'b00, i_pkt_rdata};

    // chunk length and masking for the row being emitted
    assign w_base = 9'({r_row, 3'b000});
    assign w_left = (r_len > w_base[7:0] && w_base[8] == 1'b0) ?
                    ({1'b0, r_len} - w_base) : 9'd0;
    assign w_cnt  = (w_left > 9'd8) ? 4'd8 : w_left[3:0];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_word[i*8 +: 8] = (4'(i) < w_cnt) ? i_txt_rdata[i*8 +: 8] : 8'h00;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_txt_rrow  = r_row;
    assign o_txt_wrow  = r_len[RW+2:3];
    assign o_txt_wlane = r_len[2:0];

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pos       = r_pos;
        n_start     = r_start;
        n_len       = r_len;
        n_hops      = r_hops;
        n_jumped    = r_jumped;
        n_consumed  = r_consumed;
        n_rem       = r_rem;
        n_ptr_hi    = r_ptr_hi;
        n_row       = r_row;
        w_err       = 1'b0;
        w_err_code  = dnd_pkg::ST_OK;
        o_pkt_we    = 1'b0;
        o_pkt_waddr = AW'(i_in_item.address);
        o_pkt_wdata = i_in_item.data_byte;
        o_pkt_raddr = r_pos[AW-1:0];
        o_txt_we    = 1'b0;
        o_txt_wbyte = i_pkt_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.opcode == dnd_pkg::OP_LOAD) begin
                        o_pkt_we = (POS_W'(i_in_item.address) < PB_POS);
                    end else begin
                        n_pos      = POS_W'(i_in_item.address);
                        n_start    = i_in_item.address;
                        n_len      = '0;
                        n_hops     = '0;
                        n_jumped   = 1'b0;
                        n_consumed = '0;
                        n_state    = S_LEN_ISSUE;
                    end
                end
            end
            S_LEN_ISSUE: begin
                if (r_pos >= PB_POS) begin
                    w_err      = 1'b1;
                    w_err_code = dnd_pkg::ST_PAST_END;
                end else begin
                    n_state = S_LEN_WAIT;
                end
            end
            S_LEN_WAIT: begin
                if (i_pkt_rdata == 8'd0) begin
                    if (!r_jumped) begin
                        n_consumed = 10'(w_rel + POS_W'(1));
                    end
                    n_row   = '0;
                    n_state = S_EMIT_RD;
                end else if (i_pkt_rdata >= dnd_pkg::PTR_MARK) begin
                    if (w_pos_p1 >= PB_POS) begin
                        w_err      = 1'b1;
                        w_err_code = dnd_pkg::ST_PAST_END;
                    end else begin
                        o_pkt_raddr = w_pos_p1[AW-1:0];
                        n_ptr_hi    = i_pkt_rdata[5:0];
                        n_state     = S_PTR;
                    end
                end else if (w_need > NAME_MAX) begin
                    w_err      = 1'b1;
                    w_err_code = dnd_pkg::ST_TOO_LONG;
                end else if (w_pos_pb >= PB_POS) begin
                    w_err      = 1'b1;
                    w_err_code = dnd_pkg::ST_PAST_END;
                end else begin
                    // separator before every label but the first
                    if (r_len != '0) begin
                        o_txt_we    = 1'b1;
                        o_txt_wbyte = dnd_pkg::DOT_CHAR;
                        n_len       = r_len + 1'b1;
                    end
                    o_pkt_raddr = w_pos_p1[AW-1:0];
                    n_pos       = r_pos + POS_W'(2);
                    n_rem       = i_pkt_rdata - 8'd1;
                    n_state     = S_LABEL;
                end
            end
            S_LABEL: begin
                // byte read last cycle lands in the text buffer
                o_txt_we = 1'b1;
                n_len    = r_len + 1'b1;
                if (r_rem != '0) begin
                    n_pos = w_pos_p1;
                    n_rem = r_rem - 8'd1;
                end else if (r_pos >= PB_POS) begin
                    w_err      = 1'b1;
                    w_err_code = dnd_pkg::ST_PAST_END;
                end else begin
                    n_state = S_LEN_WAIT;
                end
            end
            S_PTR: begin
                if (!r_jumped) begin
                    n_consumed = 10'(w_rel + POS_W'(2));
                    n_jumped   = 1'b1;
                end
                if (r_hops >= i_max_hops) begin
                    w_err      = 1'b1;
                    w_err_code = dnd_pkg::ST_HOPS;
                end else begin
                    n_hops  = r_hops + 1'b1;
                    n_pos   = POS_W'({r_ptr_hi, i_pkt_rdata});
                    n_state = S_LEN_ISSUE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out.name_chunk     = w_word;
                n_out.chunk_length   = w_cnt;
                n_out.last_chunk     = (w_left <= 9'd8);
                n_out.bytes_consumed = r_consumed;
                n_out.status         = dnd_pkg::ST_OK;
                n_out_valid          = 1'b1;
                n_state              = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.last_chunk) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // any error drops the partial name and sends one status item
        if (w_err) begin
            n_out.name_chunk     = '0;
            n_out.chunk_length   = '0;
            n_out.last_chunk     = 1'b1;
            n_out.bytes_consumed = '0;
            n_out.status         = w_err_code;
            n_out_valid          = 1'b1;
            n_state              = S_EMIT_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pos      <= n_pos;
        r_start    <= n_start;
        r_len      <= n_len;
        r_hops     <= n_hops;
        r_jumped   <= n_jumped;
        r_consumed <= n_consumed;
        r_rem      <= n_rem;
        r_ptr_hi   <= n_ptr_hi;
        r_row      <= n_row;
    end

endmodule

>>> hw/rtl/dns_name_decompressor.sv
// loads go straight to the packet store and stream at one item per cycle while idle
// decode: read each length byte, copy each label character, follow each pointer,
//   then per output chunk read a text row, load the output item, await the sink
// packet store read port serves one byte per cycle and sets the walk rate
// reset clears the sequencer and output valid and sets max_pointer_hops to 16
// packet store contents are undefined after reset until loaded
// ----------------------------------------------------------------------------
// dns_name_decompressor
// dns name decompressor: packet byte store plus compressed name walker
// ----------------------------------------------------------------------------
module dns_name_decompressor #(
    parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
    parameter int NAME_MAX_BYTES = dnd_pkg::NAME_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dnd_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dnd_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_we,
    input  logic [dnd_pkg::HOPS_W-1:0]   i_cfg_wdata
);

    localparam int AW        = $clog2(PACKET_BYTES);
    localparam int TEXT_ROWS = (NAME_MAX_BYTES + 7) / 8;
    localparam int RW        = $clog2(TEXT_ROWS);

    // pointer hop limit register
    logic [dnd_pkg::HOPS_W-1:0] r_max_hops;

    // packet store port
    logic          w_pkt_we;
    logic [AW-1:0] w_pkt_waddr;
    logic [7:0]    w_pkt_wdata;
    logic [AW-1:0] w_pkt_raddr;
    logic [7:0]    w_pkt_rdata;

    // text buffer port
    logic                         w_txt_we;
    logic [RW-1:0]                w_txt_wrow;
    logic [2:0]                   w_txt_wlane;
    logic [7:0]                   w_txt_wbyte;
    logic [RW-1:0]                w_txt_rrow;
    logic [dnd_pkg::CHUNK_W-1:0]  w_txt_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hops <= dnd_pkg::MAX_HOPS_RST;
        end else if (i_cfg_we) begin
            r_max_hops <= i_cfg_wdata;
        end
    end

    // sequencer: loads go straight to the store, decodes walk it
    dnd_walker #(
        .PACKET_BYTES   (PACKET_BYTES),
        .NAME_MAX_BYTES (NAME_MAX_BYTES)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_max_hops  (r_max_hops),
        .o_pkt_we    (w_pkt_we),
        .o_pkt_waddr (w_pkt_waddr),
        .o_pkt_wdata (w_pkt_wdata),
        .o_pkt_raddr (w_pkt_raddr),
        .i_pkt_rdata (w_pkt_rdata),
        .o_txt_we    (w_txt_we),
        .o_txt_wrow  (w_txt_wrow),
        .o_txt_wlane (w_txt_wlane),
        .o_txt_wbyte (w_txt_wbyte),
        .o_txt_rrow  (w_txt_rrow),
        .i_txt_rdata (w_txt_rdata)
    );

    // packet bytes, one registered read per cycle
    dnd_pkt_mem #(
        .DEPTH (PACKET_BYTES)
    ) u_pkt_mem (
        .i_clk   (i_clk),
        .i_we    (w_pkt_we),
        .i_waddr (w_pkt_waddr),
        .i_wdata (w_pkt_wdata),
        .i_raddr (w_pkt_raddr),
        .o_rdata (w_pkt_rdata)
    );

    // dotted text, one 8-byte row read per output chunk
    dnd_text_buf #(
        .ROWS (TEXT_ROWS)
    ) u_text_buf (
        .i_clk   (i_clk),
        .i_we    (w_txt_we),
        .i_wrow  (w_txt_wrow),
        .i_wlane (w_txt_wlane),
        .i_wbyte (w_txt_wbyte),
        .i_rrow  (w_txt_rrow),
        .o_rdata (w_txt_rdata)
    );

endmodule

>>> hw/rtl/dnd_checker.sv
// ----------------------------------------------------------------------------
// dnd_checker
// port-level checks for the dns name decompressor
// ----------------------------------------------------------------------------
`include "dns_name_decompressor_defines.svh"

module dnd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_ready,
    input  dnd_pkg::t_in_item            i_in_item,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  dnd_pkg::t_out_item           o_out_item
);

    // an offered item waits for the sink
    `DND_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output item dropped while stalled")

    // the block takes no new item while a result is offered
    `DND_ASSERT_SAME(a_one_at_a_time, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready while output item pending")

    // a load never produces a result
    `DND_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_item.opcode == dnd_pkg::OP_LOAD), !o_out_valid, "load produced an output item")

    // an error item is a bare single status item
    `DND_ASSERT_SAME(a_err_shape, i_clk, i_rst_n, o_out_valid && (o_out_item.status != dnd_pkg::ST_OK), o_out_item.last_chunk && (o_out_item.chunk_length == 4'd0) && (o_out_item.name_chunk == '0) && (o_out_item.bytes_consumed == 10'd0), "error item carries name data")

    // chunk never holds more than eight characters
    `DND_ASSERT_SAME(a_chunk_len, i_clk, i_rst_n, o_out_valid, o_out_item.chunk_length <= 4'd8, "chunk length above eight")

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
